/* hdl/ppm_pkg.sv */
`default_nettype none
package ppm_pkg;

	localparam int TICK_WIDTH    = 16;
	localparam int HISTORY_DEPTH = 4;
	localparam int STALL_W       = 16;
	localparam int SCALE_W       = 8;
	localparam int PERIOD_W      = 24;
	localparam int CFG_DATA_W    = 16;
	localparam int CFG_ADDR_W    = 1;
	localparam int PROD_W        = TICK_WIDTH + SCALE_W;
	localparam int PROD_EXT_W    = PROD_W + PERIOD_W;

	localparam logic [STALL_W-1:0] STALL_LIMIT_RST  = STALL_W'(2375);
	localparam logic [SCALE_W-1:0] PERIOD_SCALE_RST = SCALE_W'(8);

	// oldest level in bit 0: 0,0,1,1
	localparam logic [HISTORY_DEPTH-1:0] EDGE_PATTERN = 4'b1100;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_STALL_LIMIT  = 1'b0,
		REG_PERIOD_SCALE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [STALL_W-1:0] stall_limit;
		logic [SCALE_W-1:0] period_scale;
	} cfg_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic                pair_done;
		logic                edge_found;
		logic                stalled;
	} res_t;

endpackage
`default_nettype wire

/* hdl/ppm_ifs.sv */
`default_nettype none
interface ppm_sample_if;
	logic valid;
	logic ready;
	logic pin_sample;
	logic speed_zero;

	modport source (output valid, output pin_sample, output speed_zero, input ready);
	modport sink (input valid, input pin_sample, input speed_zero, output ready);
endinterface

interface ppm_result_if;
	logic        valid;
	logic        ready;
	logic [23:0] period;
	logic        pair_done;
	logic        edge_found;
	logic        stalled;

	modport source (output valid, output period, output pair_done, output edge_found,
		output stalled, input ready);
	modport sink (input valid, input period, input pair_done, input edge_found,
		input stalled, output ready);
endinterface
`default_nettype wire

/* hdl/ppm_cfg.sv */
`default_nettype none
module ppm_cfg
	import ppm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	logic [STALL_W-1:0] stall_limit_q;
	logic [SCALE_W-1:0] period_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_limit_q  <= STALL_LIMIT_RST;
			period_scale_q <= PERIOD_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_STALL_LIMIT: begin
					stall_limit_q <= cfg_wdata[STALL_W-1:0];
				end
				REG_PERIOD_SCALE: begin
					period_scale_q <= cfg_wdata[SCALE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.stall_limit  = stall_limit_q;
	assign cfg.period_scale = period_scale_q;

endmodule
`default_nettype wire

/* hdl/ppm_core.sv */
`default_nettype none
module ppm_core
	import ppm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire logic pin,
	input  wire logic spd0,
	input  wire cfg_t cfg,
	output res_t      res
);

	logic                     pair_phase_q;
	logic                     first_q;
	logic [HISTORY_DEPTH-1:0] hist_q;
	logic                     armed_q;
	logic [TICK_WIDTH-1:0]    tick_q;
	logic [STALL_W-1:0]       stall_q;
	logic [PERIOD_W-1:0]      period_q;

	logic                     level;
	logic [HISTORY_DEPTH-1:0] hist_d;
	logic [TICK_WIDTH-1:0]    tick_inc;
	logic [PROD_EXT_W-1:0]    prod_ext;
	logic [PERIOD_W-1:0]      prod_sat;
	logic                     edge_hit;
	logic                     same;
	logic [STALL_W-1:0]       stall_inc;
	logic                     stall_hit;
	logic [PERIOD_W-1:0]      period_d;
	logic [TICK_WIDTH-1:0]    tick_d;
	logic [STALL_W-1:0]       stall_d;

	always_comb begin
		level     = first_q | pin;
		hist_d    = {level, hist_q[HISTORY_DEPTH-1:1]};
		tick_inc  = (armed_q && (tick_q != '1)) ? tick_q + TICK_WIDTH'(1) : tick_q;
		prod_ext  = PROD_EXT_W'(tick_inc) * PROD_EXT_W'(cfg.period_scale);
		prod_sat  = (|prod_ext[PROD_EXT_W-1:PERIOD_W]) ? '1 : prod_ext[PERIOD_W-1:0];
		edge_hit  = (hist_d == EDGE_PATTERN);
		same      = (hist_d == '0) || (hist_d == '1);
		stall_inc = stall_q + STALL_W'(1);
		stall_hit = same && (stall_inc == cfg.stall_limit);

		period_d = period_q;
		if (edge_hit) begin
			period_d = prod_sat;
		end
		if (stall_hit || spd0) begin
			period_d = '0;
		end
		tick_d  = edge_hit ? '0 : tick_inc;
		stall_d = (same && !stall_hit) ? stall_inc : '0;

		if (pair_phase_q) begin
			res.period     = period_d;
			res.pair_done  = 1'b1;
			res.edge_found = edge_hit;
			res.stalled    = stall_hit;
		end else begin
			res.period     = period_q;
			res.pair_done  = 1'b0;
			res.edge_found = 1'b0;
			res.stalled    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_phase_q <= 1'b0;
			first_q      <= 1'b0;
			hist_q       <= '0;
			armed_q      <= 1'b0;
			tick_q       <= '0;
			stall_q      <= '0;
			period_q     <= '0;
		end else if (step) begin
			pair_phase_q <= !pair_phase_q;
			if (!pair_phase_q) begin
				first_q <= pin;
			end else begin
				first_q  <= 1'b0;
				hist_q   <= hist_d;
				armed_q  <= armed_q | edge_hit;
				tick_q   <= tick_d;
				stall_q  <= stall_d;
				period_q <= period_d;
			end
		end
	end

`ifndef SYNTH
	a_phase_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (pair_phase_q != $past(pair_phase_q)))
		else $error("pair phase did not advance");

	a_flags_need_pair: assert property (@(posedge clk) disable iff (!arst_n)
		!res.pair_done |-> (!res.edge_found && !res.stalled))
		else $error("flag raised without a completed pair");

	a_edge_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.edge_found) |=> (armed_q && (tick_q == '0)))
		else $error("edge did not arm and clear tick count");

	a_stall_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.stalled) |=> ((period_q == '0) && (stall_q == '0)))
		else $error("stall did not clear period");

	a_first_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !pair_phase_q) |=> $stable(period_q))
		else $error("period changed on first sample of a pair");
`endif

endmodule
`default_nettype wire

/* hdl/pulse_period_meter.sv */
`default_nettype none
// channel  | dir  | payload
// samples  | sink | pin_sample, speed_zero
// results  | src  | period[23:0], pair_done, edge_found, stalled
// One request per cycle unless stalled; the sample is held in s1, its result in out_q.
// The pair/history update is computed combinationally from the input register.
// Reset clears history, arming, counters and period; config resets to 2375 / 8.
// A stalled result register holds and blocks the input register; if full it drops ready.
module pulse_period_meter
	import ppm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	ppm_sample_if.sink                 samples,
	ppm_result_if.source               results
);

	cfg_t cfg;
	res_t res;

	logic valid_s1;
	logic pin_s1;
	logic spd_s1;
	logic out_valid_q;
	res_t out_q;
	logic adv;
	logic step;

	ppm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign adv  = !out_valid_q || results.ready;
	assign step = valid_s1 && adv;
	assign samples.ready = !valid_s1 || adv;

	ppm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.pin    (pin_s1),
		.spd0   (spd_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (samples.ready) begin
				valid_s1 <= samples.valid;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			pin_s1 <= samples.pin_sample;
			spd_s1 <= samples.speed_zero;
		end
		if (step) begin
			out_q <= res;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.period     = out_q.period;
	assign results.pair_done  = out_q.pair_done;
	assign results.edge_found = out_q.edge_found;
	assign results.stalled    = out_q.stalled;

endmodule
`default_nettype wire
